### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros sample on clk and are
// disabled while rst_n is low, so the using module must have those names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### rtl/rqc_pkg.sv
package rqc_pkg;

  // Field widths.
  localparam int unsigned COORD_W = 24;
  localparam int unsigned ANGLE_W = 15;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned SIZE_W  = 12;
  localparam int unsigned EXT_W   = SCALE_W + SIZE_W;  // scale * size, Q.12
  localparam int unsigned ROT_W   = 32;                // CORDIC x, y, z in Q2.30
  localparam int unsigned REM_W   = 13;                // angle inside one quadrant
  localparam int unsigned PROD_W  = EXT_W + 1 + ROT_W; // extent * cos/sin
  localparam int unsigned SUM_W   = PROD_W + 1;        // two products combined
  localparam int unsigned FRAC_SHIFT = 35;             // Q.42 halved down to Q.8
  localparam int unsigned NUM_COORDS = 8;

  // Angle units: 1/64 degree.
  localparam int DEG_HALF_TURN      = 180;
  localparam int UNITS_PER_QUADRANT = DEG_HALF_TURN * 64 / 2;

  localparam logic [18:0] RAD_Q30_PER_UNIT = 19'd292818;
  localparam logic signed [ROT_W-1:0] CORDIC_GAIN_INV = 32'sd652032874;

  // Arctangent of 2^-i in Q2.30 radians.
  localparam int ATAN_ENTRIES = 24;
  localparam logic [ROT_W-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // Rounding constant: one half of the final Q.8 step.
  localparam logic signed [SUM_W-1:0] ROUND_HALF =
    {{(SUM_W-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}};

  typedef logic signed [COORD_W-1:0] coord_t;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_SPRITE_WIDTH  = 1'b0,
    REG_SPRITE_HEIGHT = 1'b1
  } reg_idx_t;

  // Rotation vector and residual angle carried down the CORDIC row.
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
  } rot_t;

  // Per-sprite values that ride alongside the rotation.
  typedef struct packed {
    coord_t           cx;
    coord_t           cy;
    logic [1:0]       quad;
    logic [EXT_W-1:0] ext_w;
    logic [EXT_W-1:0] ext_h;
  } side_t;

  // Eight unrounded corner offsets, corner0_x in the lowest slot.
  typedef logic [NUM_COORDS-1:0][SUM_W-1:0] sums_t;

endpackage

### rtl/rotated_quad_corners.sv
// rotated_quad_corners takes one sprite word (centre, angle in 1/64 degree,
// Q4.12 scale) per cycle while the output is not stalled, and returns the four
// corners of the scaled, rotated sprite rectangle in signed Q16.8, saturated,
// in the order (-w,+h), (-w,-h), (+w,-h), (+w,+h). The pipeline is a row of
// rotation cells, CORDIC_STAGES of them up to the length of the arctangent
// table, behind two setup stages and ahead of three product, sum and rounding
// stages. Every stage has its own valid flag, so back-pressure on the output
// only stalls stages that are full and bubbles are squeezed out. Width and
// height registers reset to zero; the user must write them through the cfg
// port only while no word is in flight, which the block does not enforce.
`include "assert_macros.svh"

module rotated_quad_corners
  import rqc_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  // Configuration write port.
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [11:0]   cfg_wdata,
  // Input words.
  input  logic          in_tvalid,
  output logic          in_tready,
  // in_tdata, from bit 0: centre_x[23:0], centre_y[47:24], angle[62:48],
  // scale_factor[78:63], zero[79].
  input  logic [79:0]   in_tdata,
  // Result words.
  output logic          out_tvalid,
  input  logic          out_tready,
  // out_tdata, from bit 0: corner0_x, corner0_y, corner1_x, corner1_y,
  // corner2_x, corner2_y, corner3_x, corner3_y, 24 bits each.
  output logic [191:0]  out_tdata
);

  localparam int NCELLS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int DEPTH  = NCELLS + 5;
  localparam int OCC_W  = $clog2(DEPTH + 1);

  logic [SIZE_W-1:0] sprite_width_r, sprite_width_nxt;
  logic [SIZE_W-1:0] sprite_height_r, sprite_height_nxt;

  logic  chain_vld [NCELLS+1];
  logic  chain_rdy [NCELLS+1];
  rot_t  chain_rot [NCELLS+1];
  side_t chain_side [NCELLS+1];

  logic   cmb_vld, cmb_rdy;
  sums_t  cmb_sums;
  coord_t cmb_cx, cmb_cy;

  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             in_acc, out_acc;

  // Size registers.
  always_comb begin
    sprite_width_nxt  = sprite_width_r;
    sprite_height_nxt = sprite_height_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SPRITE_WIDTH:  sprite_width_nxt  = cfg_wdata;
        REG_SPRITE_HEIGHT: sprite_height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sprite_width_r  <= '0;
      sprite_height_r <= '0;
    end else begin
      sprite_width_r  <= sprite_width_nxt;
      sprite_height_r <= sprite_height_nxt;
    end
  end

  // Angle reduction, scaled extents and CORDIC start vector.
  rqc_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .centre_x      (in_tdata[23:0]),
    .centre_y      (in_tdata[47:24]),
    .angle         (in_tdata[62:48]),
    .scale_factor  (in_tdata[78:63]),
    .sprite_width  (sprite_width_r),
    .sprite_height (sprite_height_r),
    .out_valid     (chain_vld[0]),
    .out_ready     (chain_rdy[0]),
    .out_rot       (chain_rot[0]),
    .out_side      (chain_side[0])
  );

  // Row of rotation cells, one shift amount each.
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    rqc_cordic_cell #(.STAGE(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_vld[i]),
      .in_ready  (chain_rdy[i]),
      .in_rot    (chain_rot[i]),
      .in_side   (chain_side[i]),
      .out_valid (chain_vld[i+1]),
      .out_ready (chain_rdy[i+1]),
      .out_rot   (chain_rot[i+1]),
      .out_side  (chain_side[i+1])
    );
  end

  // Quadrant mapping, products and corner sums.
  rqc_combine u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_vld[NCELLS]),
    .in_ready  (chain_rdy[NCELLS]),
    .in_rot    (chain_rot[NCELLS]),
    .in_side   (chain_side[NCELLS]),
    .out_valid (cmb_vld),
    .out_ready (cmb_rdy),
    .out_sums  (cmb_sums),
    .out_cx    (cmb_cx),
    .out_cy    (cmb_cy)
  );

  // Rounding, centre offset, saturation and the output register.
  rqc_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cmb_vld),
    .in_ready   (cmb_rdy),
    .in_sums    (cmb_sums),
    .in_cx      (cmb_cx),
    .in_cy      (cmb_cy),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_coords (out_tdata)
  );

  // Words in flight, for the checks below.
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign occ_nxt = occ_r + OCC_W'(in_acc) - OCC_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  `ASSERT_CLK(a_ready_when_drained, !out_tvalid |-> in_tready, "input stalled with empty output")
  `ASSERT_CLK(a_occ_bound, occ_r <= OCC_W'(DEPTH), "more words in flight than stages")
  `ASSERT_NEVER(a_out_without_word, out_tvalid && (occ_r == '0), "result with no word in flight")

endmodule

### rtl/rqc_prep.sv
module rqc_prep
  import rqc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  coord_t             centre_x,
  input  coord_t             centre_y,
  input  logic [ANGLE_W-1:0] angle,
  input  logic [SCALE_W-1:0] scale_factor,
  input  logic [SIZE_W-1:0]  sprite_width,
  input  logic [SIZE_W-1:0]  sprite_height,
  output logic               out_valid,
  input  logic               out_ready,
  output rot_t               out_rot,
  output side_t              out_side
);

  // Start of each quadrant bin over the whole 15 bit angle range.
  localparam logic [ANGLE_W-1:0] BASE1 = ANGLE_W'(UNITS_PER_QUADRANT);
  localparam logic [ANGLE_W-1:0] BASE2 = ANGLE_W'(2 * UNITS_PER_QUADRANT);
  localparam logic [ANGLE_W-1:0] BASE3 = ANGLE_W'(3 * UNITS_PER_QUADRANT);
  localparam logic [ANGLE_W-1:0] BASE4 = ANGLE_W'(4 * UNITS_PER_QUADRANT);
  localparam logic [ANGLE_W-1:0] BASE5 = ANGLE_W'(5 * UNITS_PER_QUADRANT);

  logic               s1_v_r, s1_v_nxt;
  logic [REM_W-1:0]   s1_rem_r;
  side_t              s1_side_r;
  logic               s2_v_r, s2_v_nxt;
  rot_t               s2_rot_r;
  side_t              s2_side_r;
  logic               s1_rdy, s2_rdy;
  logic [1:0]         quad;
  logic [ANGLE_W-1:0] base;
  logic [ANGLE_W-1:0] rem_full;

  assign s2_rdy   = !s2_v_r || out_ready;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;
  assign s1_v_nxt = s1_rdy ? in_valid : s1_v_r;
  assign s2_v_nxt = s2_rdy ? s1_v_r : s2_v_r;

  // Pick the quadrant bin; a full turn folds back onto quadrants 0 and 1.
  always_comb begin
    priority if (angle >= BASE5) begin
      quad = 2'd1;
      base = BASE5;
    end else if (angle >= BASE4) begin
      quad = 2'd0;
      base = BASE4;
    end else if (angle >= BASE3) begin
      quad = 2'd3;
      base = BASE3;
    end else if (angle >= BASE2) begin
      quad = 2'd2;
      base = BASE2;
    end else if (angle >= BASE1) begin
      quad = 2'd1;
      base = BASE1;
    end else begin
      quad = 2'd0;
      base = '0;
    end
  end

  assign rem_full = angle - base;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // First stage: quadrant split and the two scaled extents.
  always_ff @(posedge clk) begin
    if (in_valid && s1_rdy) begin
      s1_rem_r        <= rem_full[REM_W-1:0];
      s1_side_r.cx    <= centre_x;
      s1_side_r.cy    <= centre_y;
      s1_side_r.quad  <= quad;
      s1_side_r.ext_w <= EXT_W'(scale_factor * sprite_width);
      s1_side_r.ext_h <= EXT_W'(scale_factor * sprite_height);
    end
  end

  // Second stage: residual angle to Q2.30 radians, CORDIC start vector.
  always_ff @(posedge clk) begin
    if (s1_v_r && s2_rdy) begin
      s2_rot_r.x <= CORDIC_GAIN_INV;
      s2_rot_r.y <= '0;
      s2_rot_r.z <= $signed(ROT_W'(s1_rem_r * RAD_Q30_PER_UNIT));
      s2_side_r  <= s1_side_r;
    end
  end

  assign out_valid = s2_v_r;
  assign out_rot   = s2_rot_r;
  assign out_side  = s2_side_r;

endmodule

### rtl/rqc_cordic_cell.sv
module rqc_cordic_cell
  import rqc_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  rot_t  in_rot,
  input  side_t in_side,
  output logic  out_valid,
  input  logic  out_ready,
  output rot_t  out_rot,
  output side_t out_side
);

  localparam logic signed [ROT_W-1:0] ATAN_STEP = $signed(ATAN_Q30[STAGE]);

  logic                    v_r, v_nxt;
  rot_t                    rot_r, rot_nxt;
  side_t                   side_r;
  logic signed [ROT_W-1:0] xs, ys;

  assign in_ready = !v_r || out_ready;
  assign v_nxt    = in_ready ? in_valid : v_r;

  // One micro-rotation; the sign of the residual angle picks the direction.
  always_comb begin
    xs = in_rot.x >>> STAGE;
    ys = in_rot.y >>> STAGE;
    if (!in_rot.z[ROT_W-1]) begin
      rot_nxt.x = in_rot.x - ys;
      rot_nxt.y = in_rot.y + xs;
      rot_nxt.z = in_rot.z - ATAN_STEP;
    end else begin
      rot_nxt.x = in_rot.x + ys;
      rot_nxt.y = in_rot.y - xs;
      rot_nxt.z = in_rot.z + ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rot_r  <= rot_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = v_r;
  assign out_rot   = rot_r;
  assign out_side  = side_r;

endmodule

### rtl/rqc_combine.sv
module rqc_combine
  import rqc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  rot_t   in_rot,
  input  side_t  in_side,
  output logic   out_valid,
  input  logic   out_ready,
  output sums_t  out_sums,
  output coord_t out_cx,
  output coord_t out_cy
);

  logic                     m_v_r, m_v_nxt;
  logic signed [PROD_W-1:0] p_wc_r, p_hs_r, p_ws_r, p_hc_r;
  coord_t                   m_cx_r, m_cy_r;
  logic                     s_v_r, s_v_nxt;
  sums_t                    s_sums_r;
  coord_t                   s_cx_r, s_cy_r;
  logic                     m_rdy, s_rdy;
  logic signed [ROT_W-1:0]  cos_v, sin_v;
  logic signed [EXT_W:0]    ew, eh;
  logic signed [SUM_W-1:0]  a, b, c, d;

  assign s_rdy    = !s_v_r || out_ready;
  assign m_rdy    = !m_v_r || s_rdy;
  assign in_ready = m_rdy;
  assign m_v_nxt  = m_rdy ? in_valid : m_v_r;
  assign s_v_nxt  = s_rdy ? m_v_r : s_v_r;

  // Map the first-quadrant cosine and sine to the full turn.
  always_comb begin
    unique case (in_side.quad)
      2'd0: begin
        cos_v = in_rot.x;
        sin_v = in_rot.y;
      end
      2'd1: begin
        cos_v = -in_rot.y;
        sin_v = in_rot.x;
      end
      2'd2: begin
        cos_v = -in_rot.x;
        sin_v = -in_rot.y;
      end
      default: begin
        cos_v = in_rot.y;
        sin_v = -in_rot.x;
      end
    endcase
  end

  assign ew = $signed({1'b0, in_side.ext_w});
  assign eh = $signed({1'b0, in_side.ext_h});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else begin
      m_v_r <= m_v_nxt;
      s_v_r <= s_v_nxt;
    end
  end

  // Four products of the extents with cosine and sine.
  always_ff @(posedge clk) begin
    if (in_valid && m_rdy) begin
      p_wc_r <= ew * cos_v;
      p_hs_r <= eh * sin_v;
      p_ws_r <= ew * sin_v;
      p_hc_r <= eh * cos_v;
      m_cx_r <= in_side.cx;
      m_cy_r <= in_side.cy;
    end
  end

  assign a = SUM_W'(p_wc_r);
  assign b = SUM_W'(p_hs_r);
  assign c = SUM_W'(p_ws_r);
  assign d = SUM_W'(p_hc_r);

  // Corner offsets with the sign pattern of each corner.
  always_ff @(posedge clk) begin
    if (m_v_r && s_rdy) begin
      s_sums_r[0] <= -a - b;
      s_sums_r[1] <= d - c;
      s_sums_r[2] <= b - a;
      s_sums_r[3] <= -c - d;
      s_sums_r[4] <= a + b;
      s_sums_r[5] <= c - d;
      s_sums_r[6] <= a - b;
      s_sums_r[7] <= c + d;
      s_cx_r      <= m_cx_r;
      s_cy_r      <= m_cy_r;
    end
  end

  assign out_valid = s_v_r;
  assign out_sums  = s_sums_r;
  assign out_cx    = s_cx_r;
  assign out_cy    = s_cy_r;

endmodule

### rtl/rqc_finish.sv
module rqc_finish
  import rqc_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sums_t                            in_sums,
  input  coord_t                           in_cx,
  input  coord_t                           in_cy,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [NUM_COORDS-1:0][COORD_W-1:0] out_coords
);

  localparam int unsigned SH_W  = SUM_W - FRAC_SHIFT;
  localparam int unsigned ACC_W = SH_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (COORD_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(2 ** (COORD_W - 1));

  logic                                v_r, v_nxt;
  logic [NUM_COORDS-1:0][COORD_W-1:0]  coords_r, coords_nxt;
  logic signed [SUM_W-1:0]             rounded [NUM_COORDS];
  logic signed [ACC_W-1:0]             acc [NUM_COORDS];

  assign in_ready = !v_r || out_ready;
  assign v_nxt    = in_ready ? in_valid : v_r;

  // Round half up to Q.8, add the centre and clamp to the coordinate range.
  always_comb begin
    for (int k = 0; k < NUM_COORDS; k++) begin
      rounded[k] = $signed(in_sums[k]) + ROUND_HALF;
      acc[k] = ACC_W'($signed(rounded[k][SUM_W-1:FRAC_SHIFT]))
             + ACC_W'((k % 2 == 0) ? in_cx : in_cy);
      if (acc[k] > SAT_HI) begin
        coords_nxt[k] = COORD_W'(SAT_HI);
      end else if (acc[k] < SAT_LO) begin
        coords_nxt[k] = COORD_W'(SAT_LO);
      end else begin
        coords_nxt[k] = COORD_W'(acc[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      coords_r <= coords_nxt;
    end
  end

  assign out_valid  = v_r;
  assign out_coords = coords_r;

endmodule
